@@ rtl/tbt_pkg.sv @@
// Shared constants, control word types and microcode for the tangent/bitangent block.
`timescale 1ns / 1ps

package tbt_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int AXES          = 3;
    localparam int COPIES        = 3;

    typedef enum logic [2:0] {
        OPND_DU1,
        OPND_DV1,
        OPND_DU2,
        OPND_DV2,
        OPND_D1J,
        OPND_D2J
    } opnd_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_TAN,
        WR_BIT
    } wr_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACC_ZERO,
        C_DIV_BUSY,
        C_J_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [4:0] {
        U_HALT,
        U_DET_A,
        U_DET_B,
        U_DET_SUB,
        U_DET_CHK,
        U_TN_A,
        U_TN_B,
        U_TN_SUB,
        U_TN_DIV,
        U_TN_WAIT,
        U_BN_A,
        U_BN_B,
        U_BN_SUB,
        U_BN_DIV,
        U_BN_WAIT,
        U_NEXT,
        U_PUB,
        U_END
    } upc_t;

    typedef struct packed {
        opnd_t   mul_a;
        opnd_t   mul_b;
        acc_op_t acc;
        logic    det_ld;
        logic    j_clr;
        logic    j_inc;
        logic    div_go;
        wr_t     wr;
        logic    pub;
        cond_t   cond;
        upc_t    target;
    } uop_t;

    // Control store. Write-back and publish fire on the cycle the step falls through.
    function automatic uop_t ucode(upc_t pc);
        uop_t u;
        u.mul_a  = OPND_DU1;
        u.mul_b  = OPND_DV2;
        u.acc    = ACC_HOLD;
        u.det_ld = 1'b0;
        u.j_clr  = 1'b0;
        u.j_inc  = 1'b0;
        u.div_go = 1'b0;
        u.wr     = WR_NONE;
        u.pub    = 1'b0;
        u.cond   = C_NEVER;
        u.target = U_HALT;
        unique case (pc)
            U_HALT:
            begin
                u.cond = C_ALWAYS;
            end
            U_DET_A:
            begin
                u.mul_a = OPND_DU1;
                u.mul_b = OPND_DV2;
            end
            U_DET_B:
            begin
                u.mul_a = OPND_DV1;
                u.mul_b = OPND_DU2;
                u.acc   = ACC_LOAD;
            end
            U_DET_SUB:
            begin
                u.acc = ACC_SUB;
            end
            U_DET_CHK:
            begin
                u.det_ld = 1'b1;
                u.j_clr  = 1'b1;
                u.cond   = C_ACC_ZERO;
                u.target = U_PUB;
            end
            U_TN_A:
            begin
                u.mul_a = OPND_D1J;
                u.mul_b = OPND_DV2;
            end
            U_TN_B:
            begin
                u.mul_a = OPND_D2J;
                u.mul_b = OPND_DV1;
                u.acc   = ACC_LOAD;
            end
            U_TN_SUB:
            begin
                u.acc = ACC_SUB;
            end
            U_TN_DIV:
            begin
                u.div_go = 1'b1;
            end
            U_TN_WAIT:
            begin
                u.wr     = WR_TAN;
                u.cond   = C_DIV_BUSY;
                u.target = U_TN_WAIT;
            end
            U_BN_A:
            begin
                u.mul_a = OPND_D2J;
                u.mul_b = OPND_DU1;
            end
            U_BN_B:
            begin
                u.mul_a = OPND_D1J;
                u.mul_b = OPND_DU2;
                u.acc   = ACC_LOAD;
            end
            U_BN_SUB:
            begin
                u.acc = ACC_SUB;
            end
            U_BN_DIV:
            begin
                u.div_go = 1'b1;
            end
            U_BN_WAIT:
            begin
                u.wr     = WR_BIT;
                u.cond   = C_DIV_BUSY;
                u.target = U_BN_WAIT;
            end
            U_NEXT:
            begin
                u.j_inc  = 1'b1;
                u.cond   = C_J_MORE;
                u.target = U_TN_A;
            end
            U_PUB:
            begin
                u.pub    = 1'b1;
                u.cond   = C_OUT_BUSY;
                u.target = U_PUB;
            end
            U_END:
            begin
                u.cond = C_ALWAYS;
            end
            default:
            begin
                u.cond = C_ALWAYS;
            end
        endcase
        return u;
    endfunction

endpackage

@@ rtl/tbt_if.sv @@
// Valid/ready channel interfaces for vertices in and tangent-space results out.
`timescale 1ns / 1ps

interface tbt_vertex_if;
    import tbt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] tex_u;
    logic signed [DATA_W-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tbt_result_if;
    import tbt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] tan_x;
    logic signed [DATA_W-1:0] tan_y;
    logic signed [DATA_W-1:0] tan_z;
    logic signed [DATA_W-1:0] bitan_x;
    logic signed [DATA_W-1:0] bitan_y;
    logic signed [DATA_W-1:0] bitan_z;
    logic                     degenerate;
    logic                     last_copy;

    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, last_copy, input ready);
    modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                    degenerate, last_copy, output ready);
endinterface

@@ rtl/triangle_tangent_bitangent.sv @@
// Top level: vertex capture, microcoded multiply/accumulate sequencer and result copies.
`timescale 1ns / 1ps

// Usage
// vtx: one vertex per transaction (position and texture coordinate, signed fixed point).
//   The first two vertices of a triangle are captured and produce nothing.
//   The third starts the sequencer; vtx.ready stays low until it returns to halt.
// res: three transactions per triangle carrying the same tangent and bitangent;
//   last_copy marks the third. degenerate flags a zero UV determinant (vectors zero).
// Sequence: for a non-degenerate triangle the third vertex leads to the determinant,
//   then per axis two numerators, two divisions and one step, then publishing and the
//   result transaction. The one-bit-per-cycle divider, run six times per non-degenerate
//   triangle, sets the throughput; the next triangle's vertices are not taken until the
//   sequencer is back at halt. A degenerate triangle goes from the determinant check
//   straight to publishing.
// Stall: results sit in an output register; while copies wait, the next triangle's
//   vertices are taken and computed, and publishing waits until all three copies left.
// Reset: vertex phase, sequencer, output copy count cleared; no result pending.
module triangle_tangent_bitangent #(
    parameter int FRAC_BITS = tbt_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tbt_vertex_if.sink   vtx,
    tbt_result_if.source res
);
    import tbt_pkg::*;

    localparam logic [1:0] PH_V0  = 2'd0;
    localparam logic [1:0] PH_V1  = 2'd1;
    localparam logic [1:0] PH_V2  = 2'd2;
    localparam logic [1:0] J_LAST = 2'(AXES - 1);
    localparam logic [1:0] N_COPY = 2'(COPIES);

    logic [1:0] phase_reg;
    upc_t       pc_reg;
    upc_t       pc_next;
    uop_t       uop;
    logic       take;
    logic [1:0] j_reg;
    logic [1:0] cnt_reg;

    logic signed [DATA_W-1:0] in_p [AXES];
    logic signed [DATA_W-1:0] p0_reg [AXES];
    logic signed [DATA_W-1:0] d1_reg [AXES];
    logic signed [DATA_W-1:0] d2_reg [AXES];
    logic signed [DATA_W-1:0] u0_reg, v0_reg;
    logic signed [DATA_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [DATA_W-1:0] opa, opb;
    logic signed [PROD_W-1:0] prod_reg, acc_reg, det_reg;
    logic                     degen_reg;
    logic signed [DATA_W-1:0] res_tan_reg [AXES];
    logic signed [DATA_W-1:0] res_bit_reg [AXES];
    logic signed [DATA_W-1:0] out_tan_reg [AXES];
    logic signed [DATA_W-1:0] out_bit_reg [AXES];
    logic                     out_degen_reg;

    logic                     div_busy;
    logic signed [DATA_W-1:0] div_quot;
    logic                     vtx_fire;
    logic                     res_fire;
    logic                     pub_fire;
    logic                     wr_en;

    function automatic logic signed [DATA_W-1:0] sat_diff(logic signed [DATA_W-1:0] a,
                                                           logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
        begin
            return d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return d[DATA_W-1:0];
    endfunction

    assign in_p[0] = vtx.pos_x;
    assign in_p[1] = vtx.pos_y;
    assign in_p[2] = vtx.pos_z;

    assign uop      = ucode(pc_reg);
    assign vtx_fire = vtx.valid && vtx.ready;
    assign res_fire = res.valid && res.ready;
    assign wr_en    = !take;
    assign pub_fire = uop.pub && !take;

    always_comb
    begin
        unique case (uop.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_ACC_ZERO: take = acc_reg == '0;
            C_DIV_BUSY: take = div_busy;
            C_J_MORE:   take = j_reg != J_LAST;
            C_OUT_BUSY: take = cnt_reg != '0;
            default:    take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (vtx_fire && phase_reg == PH_V2)
        begin
            pc_next = U_DET_A;
        end
        else if (take)
        begin
            pc_next = uop.target;
        end
        else
        begin
            pc_next = upc_t'(pc_reg + 1'b1);
        end
    end

    always_comb
    begin
        unique case (uop.mul_a)
            OPND_DU1: opa = du1_reg;
            OPND_DV1: opa = dv1_reg;
            OPND_DU2: opa = du2_reg;
            OPND_DV2: opa = dv2_reg;
            OPND_D1J: opa = d1_reg[j_reg];
            OPND_D2J: opa = d2_reg[j_reg];
            default:  opa = du1_reg;
        endcase
    end

    always_comb
    begin
        unique case (uop.mul_b)
            OPND_DU1: opb = du1_reg;
            OPND_DV1: opb = dv1_reg;
            OPND_DU2: opb = du2_reg;
            OPND_DV2: opb = dv2_reg;
            OPND_D1J: opb = d1_reg[j_reg];
            OPND_D2J: opb = d2_reg[j_reg];
            default:  opb = dv2_reg;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_V0;
            pc_reg    <= U_HALT;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (vtx_fire)
            begin
                phase_reg <= (phase_reg == PH_V2) ? PH_V0 : phase_reg + 1'b1;
            end
            if (uop.j_clr)
            begin
                j_reg <= '0;
            end
            else if (uop.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (pub_fire)
            begin
                cnt_reg <= N_COPY;
            end
            else if (res_fire)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (vtx_fire)
        begin
            unique case (phase_reg)
                PH_V0:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        p0_reg[k] <= in_p[k];
                    end
                    u0_reg <= vtx.tex_u;
                    v0_reg <= vtx.tex_v;
                end
                PH_V1:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        d1_reg[k] <= sat_diff(in_p[k], p0_reg[k]);
                    end
                    du1_reg <= sat_diff(vtx.tex_u, u0_reg);
                    dv1_reg <= sat_diff(vtx.tex_v, v0_reg);
                end
                default:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        d2_reg[k] <= sat_diff(in_p[k], p0_reg[k]);
                    end
                    du2_reg <= sat_diff(vtx.tex_u, u0_reg);
                    dv2_reg <= sat_diff(vtx.tex_v, v0_reg);
                end
            endcase
        end

        prod_reg <= PROD_W'(opa) * PROD_W'(opb);

        unique case (uop.acc)
            ACC_HOLD: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_SUB:  acc_reg <= acc_reg - prod_reg;
            default:  acc_reg <= acc_reg;
        endcase

        if (uop.det_ld)
        begin
            det_reg   <= acc_reg;
            degen_reg <= acc_reg == '0;
        end

        if (wr_en && uop.wr == WR_TAN)
        begin
            res_tan_reg[j_reg] <= div_quot;
        end
        if (wr_en && uop.wr == WR_BIT)
        begin
            res_bit_reg[j_reg] <= div_quot;
        end

        if (pub_fire)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                out_tan_reg[k] <= degen_reg ? '0 : res_tan_reg[k];
                out_bit_reg[k] <= degen_reg ? '0 : res_bit_reg[k];
            end
            out_degen_reg <= degen_reg;
        end
    end

    tbt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (uop.div_go),
        .num   (acc_reg),
        .den   (det_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign vtx.ready      = pc_reg == U_HALT;
    assign res.valid      = cnt_reg != '0;
    assign res.last_copy  = cnt_reg == 2'd1;
    assign res.degenerate = out_degen_reg;
    assign res.tan_x      = out_tan_reg[0];
    assign res.tan_y      = out_tan_reg[1];
    assign res.tan_z      = out_tan_reg[2];
    assign res.bitan_x    = out_bit_reg[0];
    assign res.bitan_y    = out_bit_reg[1];
    assign res.bitan_z    = out_bit_reg[2];

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        uop.div_go |-> !div_busy)
        else $error("divider started while busy");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.degenerate) |->
        (res.tan_x == '0 && res.tan_y == '0 && res.tan_z == '0 &&
         res.bitan_x == '0 && res.bitan_y == '0 && res.bitan_z == '0))
        else $error("degenerate result with nonzero vectors");

    a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (vtx_fire && phase_reg == PH_V2) |=> (pc_reg == U_DET_A))
        else $error("third vertex did not start the sequencer");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res.last_copy) |=> !res.valid)
        else $error("result valid after last copy");

endmodule

@@ rtl/tbt_div.sv @@
// Radix-2 restoring divider: num * 2^FRAC_BITS / den, rounded half away, saturated to 32 bits.
`timescale 1ns / 1ps

module tbt_div #(
    parameter int FRAC_BITS = tbt_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tbt_pkg::PROD_W-1:0] num,
    input  logic signed [tbt_pkg::PROD_W-1:0] den,
    output logic                              busy,
    output logic signed [tbt_pkg::DATA_W-1:0] quot
);
    import tbt_pkg::*;

    // Quotient bits kept: anything at or above 2^31 saturates, one guard bit beyond that.
    localparam int QB  = DATA_W + 1;
    localparam int CW  = $clog2(QB + 1);
    localparam int HSH = QB - FRAC_BITS;
    localparam int NW  = PROD_W + FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } st_t;

    st_t                      st_reg;
    logic [CW-1:0]            cnt_reg;
    logic [PROD_W-1:0]        rem_reg;
    logic [PROD_W-1:0]        den_reg;
    logic [QB-1:0]            lo_reg;
    logic [QB-1:0]            q_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic signed [DATA_W-1:0] quot_reg;

    logic [PROD_W-1:0] n_mag;
    logic [PROD_W-1:0] d_mag;
    logic [NW-1:0]     n_ext;
    logic [PROD_W-1:0] n_hi;
    logic [PROD_W:0]   rem_s;
    logic [PROD_W:0]   rem_sub;
    logic              ge;
    logic              rnd;
    logic [QB:0]       qr;
    logic              sat;

    always_comb
    begin
        n_mag   = num[PROD_W-1] ? (~num + 1'b1) : num;
        d_mag   = den[PROD_W-1] ? (~den + 1'b1) : den;
        n_ext   = {n_mag, {FRAC_BITS{1'b0}}};
        n_hi    = n_mag >> HSH;
        rem_s   = {rem_reg, lo_reg[QB-1]};
        rem_sub = rem_s - {1'b0, den_reg};
        ge      = rem_s >= {1'b0, den_reg};
        rnd     = {rem_reg, 1'b0} >= {1'b0, den_reg};
        qr      = {1'b0, q_reg} + (QB+1)'(rnd);
        sat     = ovf_reg | (qr[QB:DATA_W-1] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        st_reg  <= S_RUN;
                        cnt_reg <= CW'(QB);
                        rem_reg <= n_hi;
                        den_reg <= d_mag;
                        lo_reg  <= n_ext[QB-1:0];
                        q_reg   <= '0;
                        neg_reg <= num[PROD_W-1] ^ den[PROD_W-1];
                        // quotient would need more than QB bits
                        ovf_reg <= n_hi >= d_mag;
                    end
                end
                S_RUN:
                begin
                    rem_reg <= ge ? rem_sub[PROD_W-1:0] : rem_s[PROD_W-1:0];
                    q_reg   <= {q_reg[QB-2:0], ge};
                    lo_reg  <= {lo_reg[QB-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        st_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (sat)
                    begin
                        quot_reg <= neg_reg ? {1'b1, {(DATA_W-1){1'b0}}}
                                            : {1'b0, {(DATA_W-1){1'b1}}};
                    end
                    else
                    begin
                        quot_reg <= neg_reg ? -$signed(qr[DATA_W-1:0])
                                            : $signed(qr[DATA_W-1:0]);
                    end
                    st_reg <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = st_reg != S_IDLE;
    assign quot = quot_reg;

endmodule
